// ===== rtl/core/positional_list_engine_macros.svh =====
// ----------------------------------------------------------------------------
// Positional list engine assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_ENGINE_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define PLE_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A consequence that must hold in the same cycle as its cause.
`define PLE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// A consequence that must hold in the cycle after its cause.
`define PLE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/ple_pkg.sv =====
// ----------------------------------------------------------------------------
// Positional list engine package
// Request and response types, opcodes, status codes and the cell control.
// ----------------------------------------------------------------------------
package ple_pkg;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_PEEK   = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [4:0]  position;
        logic [31:0] item_word;
    } ple_req_t;

    typedef struct packed {
        logic [31:0] read_word;
        logic [1:0]  status;
        logic [4:0]  count;
    } ple_rsp_t;

    // Per-cell command for one cycle. At most one of the three moves is set.
    typedef struct packed {
        logic load;        // store the request word
        logic take_left;   // take the word of the cell in front
        logic take_right;  // take the word of the cell behind
        logic hit;         // this cell is the addressed position
    } ple_cell_ctl_t;

endpackage

// ===== rtl/core/ple_cell.sv =====
// ----------------------------------------------------------------------------
// Positional list engine cell
// Holds one list entry and moves it to or from its neighbors on command.
// ----------------------------------------------------------------------------
module ple_cell #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                   clk,
    input  ple_pkg::ple_cell_ctl_t ctl,
    input  logic [DATA_WIDTH-1:0]  load_word,
    input  logic [DATA_WIDTH-1:0]  left_word,
    input  logic [DATA_WIDTH-1:0]  right_word,
    output logic [DATA_WIDTH-1:0]  word,
    output logic [DATA_WIDTH-1:0]  hit_word
);
    import ple_pkg::*;

    logic [DATA_WIDTH-1:0] word_reg;
    logic [DATA_WIDTH-1:0] word_next;

    always_comb
    begin
        word_next = word_reg;
        if (ctl.load)
        begin
            word_next = load_word;
        end
        else if (ctl.take_left)
        begin
            word_next = left_word;
        end
        else if (ctl.take_right)
        begin
            word_next = right_word;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word     = word_reg;
    assign hit_word = ctl.hit ? word_reg : '0;

endmodule

// ===== rtl/core/positional_list_engine.sv =====
// ----------------------------------------------------------------------------
// Positional list engine
// Ordered list of up to DEPTH words with insert, remove and peek by position, and clear.
// ----------------------------------------------------------------------------
// Requests enter on req_valid/req_ready and carry an opcode, a position and a
// word. Every request yields exactly one response on rsp_valid/rsp_ready with
// the word removed or peeked, a status and the new entry count.
// The list lives in a row of DEPTH cells. An insert or remove moves all
// cells behind the addressed position by one place in the same cycle. The
// response is registered in the output register or the skid entry, and one
// request per cycle is sustained while the receiver takes responses. The
// cell row together with the single fill counter allows that rate.
// A response register plus one skid entry sit on the output. When the
// receiver stalls, a second response goes to the skid entry and req_ready
// drops until the receiver takes a response.
// Reset empties the list and the output stage; entry contents are not
// cleared and are never read before being written.
// ----------------------------------------------------------------------------
module positional_list_engine #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  ple_pkg::ple_req_t req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output ple_pkg::ple_rsp_t rsp
);
    import ple_pkg::*;

    `include "positional_list_engine_macros.svh"

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;
    localparam int WIDE_W = (DATA_WIDTH > 32) ? DATA_WIDTH : 32;
    localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DEPTH);

    logic                  req_accept;
    logic                  rsp_pop;
    logic [CNT_W-1:0]      fill_reg;
    logic [CNT_W-1:0]      fill_next;
    logic [CMP_W-1:0]      fill_c;
    logic [CMP_W-1:0]      pos_c;
    logic                  do_ins;
    logic                  do_rem;
    logic [WIDE_W-1:0]     item_wide;
    logic [DATA_WIDTH-1:0] load_word;
    logic [WIDE_W-1:0]     read_wide;
    logic [CMP_W-1:0]      count_c;
    ple_rsp_t              rsp_new;

    ple_cell_ctl_t         ctl      [DEPTH];
    logic [DATA_WIDTH-1:0] cell_word[DEPTH];
    logic [DATA_WIDTH-1:0] hit_word [DEPTH];
    logic [DATA_WIDTH-1:0] sel_word;

    logic     out_valid_reg;
    logic     out_valid_next;
    logic     skid_valid_reg;
    logic     skid_valid_next;
    ple_rsp_t out_reg;
    ple_rsp_t out_next;
    ple_rsp_t skid_reg;
    ple_rsp_t skid_next;

    assign req_ready  = !skid_valid_reg;
    assign req_accept = req_valid && req_ready;
    assign rsp_pop    = out_valid_reg && rsp_ready;

    assign fill_c    = CMP_W'(fill_reg);
    assign pos_c     = CMP_W'(req.position);
    assign item_wide = WIDE_W'(req.item_word);
    assign load_word = item_wide[DATA_WIDTH-1:0];

    assign do_ins = req_accept && (req.opcode == OP_INSERT)
                    && (pos_c <= fill_c) && (fill_c != DEPTH_C);
    assign do_rem = req_accept && (req.opcode == OP_REMOVE)
                    && (fill_c != '0) && (pos_c < fill_c);

    // Cell row: each cell decodes its move from its own place in the row.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        localparam logic [CMP_W-1:0] IDX = CMP_W'(i);

        logic [DATA_WIDTH-1:0] left_word;
        logic [DATA_WIDTH-1:0] right_word;

        assign ctl[i].load       = do_ins && (IDX == pos_c);
        assign ctl[i].take_left  = do_ins && (IDX > pos_c);
        assign ctl[i].take_right = do_rem && (IDX >= pos_c);
        assign ctl[i].hit        = (IDX == pos_c);

        if (i == 0)
        begin : g_front
            assign left_word = '0;
        end
        else
        begin : g_inner_left
            assign left_word = cell_word[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_back
            assign right_word = '0;
        end
        else
        begin : g_inner_right
            assign right_word = cell_word[i+1];
        end

        ple_cell #(
            .DATA_WIDTH(DATA_WIDTH)
        ) u_cell (
            .clk       (clk),
            .ctl       (ctl[i]),
            .load_word (load_word),
            .left_word (left_word),
            .right_word(right_word),
            .word      (cell_word[i]),
            .hit_word  (hit_word[i])
        );
    end

    // At most one cell reports a hit, so an OR over the row selects it.
    always_comb
    begin
        sel_word = '0;
        for (int k = 0; k < DEPTH; k++)
        begin
            sel_word = sel_word | hit_word[k];
        end
    end

    assign read_wide = WIDE_W'(sel_word);

    always_comb
    begin
        fill_next         = fill_reg;
        rsp_new.read_word = '0;
        rsp_new.status    = ST_OK;
        case (req.opcode)
            OP_INSERT:
            begin
                if (pos_c > fill_c)
                begin
                    rsp_new.status = ST_RANGE;
                end
                else if (fill_c == DEPTH_C)
                begin
                    rsp_new.status = ST_FULL;
                end
                else
                begin
                    fill_next = fill_reg + CNT_W'(1);
                end
            end
            OP_REMOVE, OP_PEEK:
            begin
                if (fill_c == '0)
                begin
                    rsp_new.status = ST_EMPTY;
                end
                else if (pos_c >= fill_c)
                begin
                    rsp_new.status = ST_RANGE;
                end
                else
                begin
                    rsp_new.read_word = read_wide[31:0];
                    if (req.opcode == OP_REMOVE)
                    begin
                        fill_next = fill_reg - CNT_W'(1);
                    end
                end
            end
            default:
            begin
                fill_next = '0;
            end
        endcase
        count_c       = CMP_W'(fill_next);
        rsp_new.count = count_c[4:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else if (req_accept)
        begin
            fill_reg <= fill_next;
        end
    end

    // Output register with one skid entry behind it.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (req_accept)
        begin
            if (!out_valid_reg || rsp_pop)
            begin
                out_valid_next = 1'b1;
                out_next       = rsp_new;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_next       = rsp_new;
            end
        end
        else if (rsp_pop)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    `PLE_ASSERT_ALWAYS(a_fill_bound, fill_reg <= CNT_W'(DEPTH), "fill count exceeds DEPTH")
    `PLE_ASSERT_SAME(a_skid_behind_out, skid_valid_reg, out_valid_reg, "skid entry without output")
    `PLE_ASSERT_NEXT(a_fill_hold, !req_accept, $stable(fill_reg), "fill changed without request")
    `PLE_ASSERT_NEXT(a_insert_grows, do_ins, fill_reg == ($past(fill_reg) + CNT_W'(1)), "insert lost")
    `PLE_ASSERT_SAME(a_single_move, do_ins, !do_rem, "insert and remove in one cycle")

endmodule
